[rtl/duc_pkg.sv]
// Package with the item types, register map and exponential factor table.
`timescale 1ns / 1ps
package duc_pkg;

  localparam int MaxSlicesDefault = 256;
  localparam int CostBits         = 16;
  localparam int HeightBits       = 16;
  localparam int WeightSteps      = 11;
  localparam logic [63:0] ExpStepQ32 = 64'd4268311668;

  typedef enum logic [1:0] {
    REG_SLICE_COUNT = 2'd0
  } reg_addr_t;

  typedef struct packed {
    logic [CostBits-1:0]   cost;
    logic [HeightBits-1:0] height;
  } in_item_t;

  typedef struct packed {
    logic [15:0] uncertainty;
    logic        weight_underflow;
  } out_item_t;

  // F(0) = exp(-25.5/4096) in Q0.32, F(b+1) = round(F(b)^2 / 2^32).
  function automatic logic [WeightSteps-1:0][31:0] exp_factors();
    logic [63:0] f;
    logic [WeightSteps-1:0][31:0] t;
    f = ExpStepQ32;
    for (int b = 0; b < WeightSteps; b++) begin
      t[b] = f[31:0];
      f = (f * f + 64'h8000_0000) >> 32;
    end
    return t;
  endfunction

endpackage

[rtl/duc_front.sv]
// Front end: accepts cost items and assigns each its slice number within the pixel.
`timescale 1ns / 1ps
module duc_front #(
  parameter int MAX_SLICES = duc_pkg::MaxSlicesDefault,
  parameter int KW = $clog2(MAX_SLICES),
  parameter int SW = $clog2(MAX_SLICES + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [8:0]       slice_count,
  input  logic             q_full,
  output logic             push,
  output logic [KW-1:0]    push_k,
  output logic [SW-1:0]    push_s,
  output logic             push_last
);

  logic [KW-1:0] slice_index;
  logic [11:0]   cnt_ext;
  logic [11:0]   s_ext;
  logic [11:0]   k_ext;

  always_comb begin
    cnt_ext = 12'(slice_count);
    if (cnt_ext == 12'd0) begin
      s_ext = 12'd1;
    end else if (cnt_ext > 12'(MAX_SLICES)) begin
      s_ext = 12'(MAX_SLICES);
    end else begin
      s_ext = cnt_ext;
    end
    k_ext = 12'(slice_index);
    if (k_ext >= s_ext) begin
      k_ext = s_ext - 12'd1;
    end
  end

  assign push_s    = SW'(s_ext);
  assign push_k    = KW'(k_ext);
  assign push_last = (k_ext + 12'd1) >= s_ext;
  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_index <= '0;
    end else if (push) begin
      slice_index <= push_last ? '0 : KW'(k_ext + 12'd1);
    end
  end

endmodule

[rtl/duc_queue.sv]
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
module duc_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] rdata
);

  logic [1:0][W-1:0] store;
  logic              wptr;
  logic              rptr;
  logic [1:0]        count;

  assign full  = count == 2'd2;
  assign valid = count != 2'd0;
  assign rdata = store[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("Item written into a full queue.");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("Item taken from an empty queue.");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("Queue count out of range.");
`endif

endmodule

[rtl/duc_div.sv]
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module duc_div #(
  parameter int NW = 64,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quot
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] acc;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic          qbit;

  assign trial = {rem, acc[NW-1]};
  assign qbit  = trial >= {1'b0, dvs};
  assign quot  = acc;

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= num;
      rem <= '0;
      dvs <= den;
    end else if (busy) begin
      acc <= {acc[NW-2:0], qbit};
      rem <= qbit ? DW'(trial - {1'b0, dvs}) : DW'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
    end else if (busy) begin
      cnt  <= cnt - CW'(1);
      busy <= cnt != CW'(1);
    end
  end

endmodule

[rtl/duc_sqrt.sv]
// Integer square root of a 64-bit value, two radicand bits per cycle.
`timescale 1ns / 1ps
module duc_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        busy,
  output logic [32:0] root
);

  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root  = 33'(res);

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= value;
      res  <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (v >= trial) begin
        v   <= v - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && bitv[0]) begin
      busy <= 1'b0;
    end
  end

endmodule

[rtl/duc_back.sv]
// Back end: weight, spread accumulation and the per-pixel result.
`timescale 1ns / 1ps
module duc_back #(
  parameter int KW = 8,
  parameter int SW = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  duc_pkg::in_item_t   q_item,
  input  logic [KW-1:0]       q_k,
  input  logic [SW-1:0]       q_s,
  input  logic                q_last,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output duc_pkg::out_item_t  out_item
);

  localparam int CNW = KW + 18;
  localparam int StepsW = $clog2(duc_pkg::WeightSteps + 1);
  localparam logic [duc_pkg::WeightSteps-1:0][31:0] Factors = duc_pkg::exp_factors();

  typedef enum logic [2:0] {
    S_IDLE, S_WEIGHT, S_SQUARE, S_TERM, S_ACC, S_FINAL, S_DIV, S_SQRT
  } state_t;

  state_t          state;
  logic [15:0]     cost;
  logic [15:0]     height;
  logic            last;
  logic [32:0]     p;
  logic [StepsW-1:0] step;
  logic [16:0]     w;
  logic [15:0]     diff;
  logic [31:0]     d2;
  logic [32:0]     term;
  logic [31:0]     wsum;
  logic [47:0]     spread;
  logic            emit;

  logic [64:0]     prod;
  logic [48:0]     wd;
  logic [48:0]     ssum;
  logic [15:0]     center;
  logic            cdiv_start;
  logic            cdiv_busy;
  logic [CNW-1:0]  cdiv_quot;
  logic            bdiv_start;
  logic            bdiv_busy;
  logic [63:0]     bdiv_quot;
  logic            sq_start;
  logic            sq_busy;
  logic [32:0]     sq_root;

  assign pop        = state == S_IDLE && q_valid && !emit;
  assign cdiv_start = pop;
  assign bdiv_start = state == S_FINAL && wsum != 32'd0 && !emit;
  assign sq_start   = state == S_DIV && !bdiv_busy;
  assign center     = cdiv_quot[15:0];
  assign prod       = 65'(p) * 65'(Factors[step[3:0]]);
  assign wd         = 49'(w) * 49'(d2);
  assign ssum       = 49'(spread) + 49'(term);

  duc_div #(.NW(CNW), .DW(SW + 1)) u_cdiv (
    .clk(clk), .rst(rst), .start(cdiv_start),
    .num((CNW'({q_k, 1'b1}) << 16) + CNW'(q_s)),
    .den({q_s, 1'b0}),
    .busy(cdiv_busy), .quot(cdiv_quot)
  );

  duc_div #(.NW(64), .DW(32)) u_bdiv (
    .clk(clk), .rst(rst), .start(bdiv_start),
    .num({spread, 16'd0}), .den(wsum),
    .busy(bdiv_busy), .quot(bdiv_quot)
  );

  duc_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .value(bdiv_quot),
    .busy(sq_busy), .root(sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      emit      <= 1'b0;
      wsum      <= '0;
      spread    <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (emit && !out_valid) begin
        out_valid <= 1'b1;
        emit      <= 1'b0;
        wsum      <= '0;
        spread    <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            cost   <= q_item.cost;
            height <= q_item.height;
            last   <= q_last;
            p      <= 33'h1_0000_0000;
            step   <= '0;
            state  <= S_WEIGHT;
          end
        end
        S_WEIGHT: begin
          if (step != StepsW'(duc_pkg::WeightSteps)) begin
            if (cost[step[3:0]]) begin
              p <= 33'((prod + 65'h8000_0000) >> 32);
            end
            step <= step + StepsW'(1);
          end else if (!cdiv_busy) begin
            w     <= (cost[15:11] != 5'd0) ? 17'd0 : 17'((34'(p) + 34'd32768) >> 16);
            diff  <= (center >= height) ? center - height : height - center;
            state <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          d2    <= 32'(diff) * 32'(diff);
          state <= S_TERM;
        end
        S_TERM: begin
          term  <= 33'((wd + 49'd32768) >> 16);
          state <= S_ACC;
        end
        S_ACC: begin
          wsum   <= wsum + 32'(w);
          spread <= ssum[48] ? '1 : ssum[47:0];
          state  <= last ? S_FINAL : S_IDLE;
        end
        S_FINAL: begin
          if (!emit) begin
            if (wsum == 32'd0) begin
              if (!out_valid) begin
                out_item.uncertainty      <= 16'hFFFF;
                out_item.weight_underflow <= 1'b1;
                emit                      <= 1'b1;
                state                     <= S_IDLE;
              end
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (!bdiv_busy) begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (!sq_busy && !out_valid) begin
            out_item.uncertainty      <= (sq_root > 33'hFFFF) ? 16'hFFFF : sq_root[15:0];
            out_item.weight_underflow <= 1'b0;
            emit                      <= 1'b1;
            state                     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_underflow_saturates: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_item.weight_underflow |-> out_item.uncertainty == 16'hFFFF)
    else $error("Underflow flag raised without a saturated result.");
  a_center_done: assert property (@(posedge clk) disable iff (rst)
      state == S_SQUARE |-> !cdiv_busy)
    else $error("Slice centre used before the divider finished.");
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
      emit && !out_valid |=> wsum == 32'd0 && spread == 48'd0)
    else $error("Accumulators not cleared after a pixel result.");
`endif

endmodule

[rtl/depth_uncertainty_from_cost.sv]
// Top level of the depth uncertainty block with its configuration register.
// Usage: each item on the input channel (in_valid, in_stall, in_item) carries one
// slice's matching cost and the pixel's height. After slice_count items, clamped to
// 1 to MAX_SLICES, one result item (uncertainty, weight_underflow) appears on the
// output channel (out_valid, out_stall, out_item). An item is taken at a clock edge
// where valid is high and stall is low.
// The time each slice spends in the back end is set by the iterative divider
// that forms the slice centre. The last slice of a pixel adds the 64-step
// division and the 32-step square root. A two-item queue lets the front end
// take items while the back end works, and the result register frees the back
// end once it is written.
// Reset clears the slice position, the accumulators and both channels, and sets
// slice_count to 64. While the receiver stalls, the result is held, the back end
// waits to write the next one, the queue fills and in_stall rises. The user writes
// slice_count over APB at address 0 only while the block idles; it is not enforced.
`timescale 1ns / 1ps
module depth_uncertainty_from_cost #(
  parameter int MAX_SLICES = duc_pkg::MaxSlicesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  duc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output duc_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int KW = $clog2(MAX_SLICES);
  localparam int SW = $clog2(MAX_SLICES + 1);
  localparam int QW = KW + SW + 1 + $bits(duc_pkg::in_item_t);

  logic [8:0]    slice_count;
  logic          q_full;
  logic          push;
  logic [KW-1:0] push_k;
  logic [SW-1:0] push_s;
  logic          push_last;
  logic          pop;
  logic          q_valid;
  logic [QW-1:0] q_data;
  duc_pkg::in_item_t q_item;
  logic [KW-1:0] q_k;
  logic [SW-1:0] q_s;
  logic          q_last;

  assign pready = 1'b1;
  assign prdata = (paddr == duc_pkg::REG_SLICE_COUNT) ? 32'(slice_count) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_count <= 9'd64;
    end else if (psel && penable && pwrite && paddr == duc_pkg::REG_SLICE_COUNT) begin
      slice_count <= pwdata[8:0];
    end
  end

  duc_front #(.MAX_SLICES(MAX_SLICES), .KW(KW), .SW(SW)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .slice_count(slice_count), .q_full(q_full), .push(push),
    .push_k(push_k), .push_s(push_s), .push_last(push_last)
  );

  duc_queue #(.W(QW)) u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata({push_k, push_s, push_last, in_item}),
    .full(q_full), .pop(pop), .valid(q_valid), .rdata(q_data)
  );

  assign {q_k, q_s, q_last, q_item} = q_data;

  duc_back #(.KW(KW), .SW(SW)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_k(q_k),
    .q_s(q_s), .q_last(q_last), .pop(pop), .out_valid(out_valid),
    .out_stall(out_stall), .out_item(out_item)
  );

endmodule

[bench/duc_checker.sv]
// Checker that predicts the depth uncertainty results and compares them with the block's output.
`timescale 1ns / 1ps
module duc_checker #(
  parameter int MAX_SLICES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  duc_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  duc_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 errors,
  output int                 pending
);

  localparam logic [63:0] Half32 = 64'h8000_0000;
  localparam logic [47:0] SpreadMax = 48'hFFFF_FFFF_FFFF;

  logic [63:0]  exp_tab [11];
  logic [8:0]   pixel_slices;
  logic [31:0]  slice_pos;
  logic [31:0]  wsum;
  logic [47:0]  spread;
  duc_pkg::out_item_t expected_results [$];

  initial begin
    logic [63:0] f;
    f = 64'd4268311668;
    for (int b = 0; b < 11; b++) begin
      exp_tab[b] = f;
      f = (f * f + Half32) >> 32;
    end
  end

  function automatic logic [16:0] weight_of(logic [15:0] c);
    logic [63:0] p;
    if (c >= 16'd2048) return 17'd0;
    p = 64'd1 << 32;
    for (int b = 0; b < 11; b++)
      if (c[b]) p = (p * exp_tab[b] + Half32) >> 32;
    return 17'((p + 64'd32768) >> 16);
  endfunction

  function automatic logic [31:0] root_of(logic [63:0] q);
    logic [31:0] r;
    logic [31:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if ({32'd0, t} * {32'd0, t} <= q) r = t;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic predict_slice(duc_pkg::in_item_t it);
    logic [31:0] s;
    logic [31:0] k;
    logic [63:0] centre;
    logic [63:0] diff;
    logic [63:0] term;
    logic [16:0] w;
    logic [63:0] q;
    logic [31:0] r;
    duc_pkg::out_item_t res;
    s = (pixel_slices == 0) ? 1 : (pixel_slices > MAX_SLICES) ? MAX_SLICES : pixel_slices;
    k = (slice_pos >= s) ? s - 1 : slice_pos;
    centre = ((64'(2 * k + 1) << 16) + s) / (64'(2) * s);
    diff = (centre >= it.height) ? centre - it.height : 64'(it.height) - centre;
    w = weight_of(it.cost);
    term = (64'(w) * (diff * diff) + 64'd32768) >> 16;
    wsum = wsum + 32'(w);
    if (term > 64'(SpreadMax - spread)) spread = SpreadMax;
    else spread = spread + 48'(term);
    if (k + 1 < s) begin
      slice_pos = k + 1;
      return;
    end
    if (wsum == 0) begin
      res.uncertainty = 16'hFFFF;
      res.weight_underflow = 1'b1;
    end else begin
      q = {spread, 16'd0} / wsum;
      r = root_of(q);
      res.uncertainty = (r > 32'hFFFF) ? 16'hFFFF : r[15:0];
      res.weight_underflow = 1'b0;
    end
    expected_results.push_back(res);
    slice_pos = 0;
    wsum = 0;
    spread = 0;
  endtask

  always @(posedge clk) begin
    duc_pkg::out_item_t want;
    if (rst) begin
      errors = 0;
      pixel_slices = 9'd64;
      slice_pos = 0;
      wsum = 0;
      spread = 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr == 2'(duc_pkg::REG_SLICE_COUNT * 4))
        pixel_slices = pwdata[8:0];
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result count", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_item.uncertainty !== want.uncertainty)
            report_mismatch("uncertainty", out_item.uncertainty, want.uncertainty);
          if (out_item.weight_underflow !== want.weight_underflow)
            report_mismatch("weight_underflow", out_item.weight_underflow,
                            want.weight_underflow);
        end
      end
      if (in_valid && !in_stall) predict_slice(in_item);
    end
    pending = expected_results.size();
  end

endmodule

[bench/depth_uncertainty_from_cost_tb.sv]
// Testbench top that drives pixels of cost slices and slice counts and gives the verdict.
`timescale 1ns / 1ps
module depth_uncertainty_from_cost_tb;

  localparam int CycleLimit = 1_500_000;
  localparam int SettleCycles = 300;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  duc_pkg::in_item_t  in_item;
  logic       out_valid;
  logic       out_stall;
  duc_pkg::out_item_t out_item;
  logic       psel;
  logic       penable;
  logic       pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic       pready;
  int         errors;
  int         pending;
  int         cycles = 0;
  int         send_idle_pct;
  int         stall_pct;
  int         hold_reqs;
  int         holds_done;
  int         slices_sent;

  depth_uncertainty_from_cost #(.MAX_SLICES(256)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  duc_checker #(.MAX_SLICES(256)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("depth_uncertainty_from_cost_tb failed");
      $finish;
    end
  end

  initial begin
    holds_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        for (int i = 0; i < 600; i++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
        holds_done++;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_slice(logic [15:0] c, logic [15:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{cost: c, height: h};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    slices_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_slice_count(logic [8:0] n);
    settle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 2'(duc_pkg::REG_SLICE_COUNT * 4);
    pwdata <= {23'd0, n};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] random_cost();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 16'($urandom_range(400));
      5, 6:          return 16'($urandom_range(2047));
      7:             return 16'($urandom_range(65535, 2048));
      default:       return 16'($urandom);
    endcase
  endfunction

  task automatic random_pixel(int n, bit dead);
    logic [15:0] h;
    h = 16'($urandom);
    for (int i = 0; i < n; i++)
      send_slice(dead ? 16'($urandom_range(65535, 2048)) : random_cost(), h);
  endtask

  initial begin
    int n;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_reqs = 0;
    slices_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset count of 64 first, then the field extremes on short pixels.
    random_pixel(64, 1'b0);
    set_slice_count(9'd2);
    send_slice(16'd0, 16'd0);
    send_slice(16'd0, 16'hFFFF);
    send_slice(16'd2047, 16'hFFFF);
    send_slice(16'd2048, 16'hFFFF);
    send_slice(16'hFFFF, 16'd0);
    send_slice(16'hFFFF, 16'd0);
    send_slice(16'd1, 16'h8000);
    send_slice(16'd1024, 16'h8000);
    set_slice_count(9'd1);
    send_slice(16'd0, 16'h8000);
    send_slice(16'd3000, 16'h1234);
    set_slice_count(9'd0);
    send_slice(16'd5, 16'hFFFF);
    send_slice(16'd0, 16'd0);
    // The count is lowered while a pixel is part way through.
    set_slice_count(9'd8);
    random_pixel(5, 1'b0);
    set_slice_count(9'd3);
    send_slice(16'd7, 16'h4000);
    set_slice_count(9'd6);
    random_pixel(4, 1'b0);
    set_slice_count(9'd4);
    send_slice(16'd100, 16'hC000);
    set_slice_count(9'd256);
    random_pixel(256, 1'b0);
    set_slice_count(9'd511);
    random_pixel(256, 1'b0);

    // A long receiver hold-off fills the block while single-slice pixels keep coming.
    set_slice_count(9'd1);
    hold_reqs++;
    for (int i = 0; i < 40; i++) random_pixel(1, 1'b0);
    settle();

    slices_sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 76 : (phase == 3) ? 26 : 0;
      stall_pct = (phase == 2) ? 76 : (phase == 3) ? 26 : 0;
      while (slices_sent < 225 * (phase + 1)) begin
        n = ($urandom_range(19) == 0) ? $urandom_range(32, 9) : $urandom_range(8, 1);
        set_slice_count(9'(n));
        repeat ($urandom_range(12, 3)) random_pixel(n, $urandom_range(11) == 0);
      end
    end
    send_idle_pct = 0;
    stall_pct = 0;
    set_slice_count(9'd300);
    random_pixel(256, 1'b0);
    settle();

    if (errors == 0 && pending == 0)
      $display("depth_uncertainty_from_cost_tb passed");
    else
      $display("depth_uncertainty_from_cost_tb failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/duc_pkg.sv
rtl/duc_front.sv
rtl/duc_queue.sv
rtl/duc_div.sv
rtl/duc_sqrt.sv
rtl/duc_back.sv
rtl/depth_uncertainty_from_cost.sv
bench/duc_checker.sv
bench/depth_uncertainty_from_cost_tb.sv
